// ===== sv/gap_merge_two_sorted_lists_macros.svh =====
// Assertion macros shared by the gap merge design.
`ifndef GAP_MERGE_TWO_SORTED_LISTS_MACROS_SVH
`define GAP_MERGE_TWO_SORTED_LISTS_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define GMSL_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define GMSL_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that holds in the cycle after its trigger.
`define GMSL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gmsl_pkg.sv =====
// Package with the payload types and fixed widths of the gap merge block.
`timescale 1ns / 1ps

package gmsl_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_COUNT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_COUNT = 2'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic                         action;
    logic signed [VALUE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] merged_value;
    logic                         from_second;
    logic                         last;
    logic                         none_left;
  } result_t;

endpackage

// ===== sv/gap_merge_two_sorted_lists.sv =====
// Top level of the gap merge block: sequencer, gap unit and result register.
`timescale 1ns / 1ps
`include "gap_merge_two_sorted_lists_macros.svh"

// Loads the first list and then the second into one store, one value per load request. The
// first read request after loading runs the gap passes over the n loaded values with one
// shared compare unit and the two-read, one-write store: each pair is read and compared,
// and a swapped pair is written back in the compare and write states; each change of gap
// is made in the read state. Every other read passes the fetch and result states to the
// result register, and the next request is taken in the cycle after the result is
// registered. A load request is taken while an earlier result still waits, but a read
// stalls the input until the waiting result is taken. Requests are held off while a
// configuration write is offered. After reset the store holds nothing useful, and only
// loaded positions are ever read.
module gap_merge_two_sorted_lists import gmsl_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  item_t                   item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output result_t                 result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SORT_RD  = 3'd1;
  localparam logic [2:0] ST_SORT_CMP = 3'd2;
  localparam logic [2:0] ST_SORT_WR  = 3'd3;
  localparam logic [2:0] ST_FETCH    = 3'd4;
  localparam logic [2:0] ST_RESULT   = 3'd5;

  localparam logic [1:0] PH_LOADING = 2'd0;
  localparam logic [1:0] PH_SORTING = 2'd1;
  localparam logic [1:0] PH_READING = 2'd2;

  logic [2:0]       state;
  logic [1:0]       phase;
  logic [CNT_W-1:0] first_count;
  logic [CNT_W-1:0] second_count;
  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] read_position;
  logic [CNT_W-1:0] current_gap;
  logic [CNT_W-1:0] scan_index;
  logic             none_flag;

  logic [CNT_W-1:0] first_next;
  logic [CNT_W-1:0] second_next;
  logic [CW-1:0]    cfg_v;
  logic [CW-1:0]    max_cw;
  logic [CW-1:0]    room0;
  logic [CW-1:0]    room1;
  logic [CW-1:0]    first_clamp;

  logic             item_fire;
  logic             cfg_fire;
  logic             cfg_hit;
  logic [CNT_W:0]   total;
  logic             load_ok;
  logic [CNT_W:0]   pair_hi;
  logic             pair_ok;
  logic [CNT_W-1:0] gap_src;
  logic [CNT_W-1:0] gap_step;
  logic             swap;
  logic             result_free;
  logic             have_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;

  assign item_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready   = (state == ST_IDLE);
  assign item_fire   = item_valid && item_ready;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign cfg_hit     = (cfg_index == REG_FIRST_COUNT) || (cfg_index == REG_SECOND_COUNT);
  assign total       = {1'b0, first_count} + {1'b0, second_count};
  assign load_ok     = (phase == PH_LOADING) && ({1'b0, loaded_count} < total);
  assign pair_hi     = {1'b0, scan_index} + {1'b0, current_gap};
  assign pair_ok     = pair_hi < {1'b0, loaded_count};
  assign swap        = $signed(rd_a) > $signed(rd_b);
  assign result_free = !result_valid || result_ready;
  assign have_next   = read_position < loaded_count;

  // Shared gap unit: ceil(g/2), and zero once the gap of one is done.
  assign gap_src  = (state == ST_IDLE) ? loaded_count : current_gap;
  assign gap_step = (gap_src <= CNT_W'(1)) ? '0 :
                    ((gap_src >> 1) + CNT_W'(gap_src[0]));

  always_comb begin
    cfg_v       = CW'(cfg_data);
    max_cw      = CW'(MAX_ITEMS);
    first_clamp = (cfg_v > max_cw) ? max_cw : cfg_v;
    room0       = max_cw - first_clamp;
    room1       = max_cw - CW'(first_count);
    first_next  = first_count;
    second_next = second_count;
    case (cfg_index)
      REG_FIRST_COUNT: begin
        first_next  = CNT_W'(first_clamp);
        second_next = (CW'(second_count) > room0) ? CNT_W'(room0) : second_count;
      end
      REG_SECOND_COUNT: begin
        second_next = (cfg_v > room1) ? CNT_W'(room1) : CNT_W'(cfg_v);
      end
      default: begin
        first_next  = first_count;
        second_next = second_count;
      end
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = loaded_count[AW-1:0];
    wdata   = item.value;
    re      = 1'b0;
    raddr_a = scan_index[AW-1:0];
    raddr_b = pair_hi[AW-1:0];
    case (state)
      ST_IDLE: begin
        we = item_fire && (item.action == ACT_LOAD) && load_ok;
      end
      ST_SORT_RD: begin
        re = (current_gap != '0) && pair_ok;
      end
      ST_SORT_CMP: begin
        we    = swap;
        waddr = scan_index[AW-1:0];
        wdata = rd_b;
      end
      ST_SORT_WR: begin
        we    = 1'b1;
        waddr = pair_hi[AW-1:0];
        wdata = rd_a;
      end
      ST_FETCH: begin
        re      = have_next;
        raddr_a = read_position[AW-1:0];
        raddr_b = read_position[AW-1:0];
      end
      default: begin
        we = 1'b0;
        re = 1'b0;
      end
    endcase
  end

  gmsl_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_LOADING;
      first_count   <= '0;
      second_count  <= '0;
      loaded_count  <= '0;
      read_position <= '0;
      current_gap   <= '0;
      scan_index    <= '0;
      none_flag     <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if ((state == ST_RESULT) && result_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_fire && cfg_hit) begin
        first_count   <= first_next;
        second_count  <= second_next;
        loaded_count  <= '0;
        read_position <= '0;
        current_gap   <= '0;
        scan_index    <= '0;
        phase         <= PH_LOADING;
      end else begin
        case (state)
          ST_IDLE: begin
            if (item_fire) begin
              if (item.action == ACT_LOAD) begin
                if (load_ok) begin
                  loaded_count <= loaded_count + CNT_W'(1);
                end
              end else if (phase != PH_READING) begin
                phase       <= PH_SORTING;
                current_gap <= gap_step;
                scan_index  <= '0;
                state       <= ST_SORT_RD;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
          ST_SORT_RD: begin
            if (current_gap == '0) begin
              phase <= PH_READING;
              state <= ST_FETCH;
            end else if (pair_ok) begin
              state <= ST_SORT_CMP;
            end else if (gap_step == '0) begin
              current_gap <= '0;
              phase       <= PH_READING;
              state       <= ST_FETCH;
            end else begin
              current_gap <= gap_step;
              scan_index  <= '0;
            end
          end
          ST_SORT_CMP: begin
            if (swap) begin
              state <= ST_SORT_WR;
            end else begin
              scan_index <= scan_index + CNT_W'(1);
              state      <= ST_SORT_RD;
            end
          end
          ST_SORT_WR: begin
            scan_index <= scan_index + CNT_W'(1);
            state      <= ST_SORT_RD;
          end
          ST_FETCH: begin
            none_flag <= !have_next;
            state     <= ST_RESULT;
          end
          ST_RESULT: begin
            if (result_free) begin
              if (!none_flag) begin
                read_position <= read_position + CNT_W'(1);
              end
              state <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && result_free) begin
      if (none_flag) begin
        result.merged_value <= '0;
        result.from_second  <= 1'b0;
        result.last         <= 1'b0;
        result.none_left    <= 1'b1;
      end else begin
        result.merged_value <= $signed(rd_a);
        result.from_second  <= read_position >= first_count;
        result.last         <= ({1'b0, read_position} + (CNT_W+1)'(1)) == {1'b0, loaded_count};
        result.none_left    <= 1'b0;
      end
    end
  end

  `GMSL_ALWAYS(a_load_bound, {1'b0, loaded_count} <= total, "too many values loaded")
  `GMSL_ALWAYS(a_read_bound, read_position <= loaded_count, "read position too far")
  `GMSL_IMP(a_pair_range, (state == ST_SORT_CMP) || (state == ST_SORT_WR), pair_ok, "bad pair")
  `GMSL_NEXT(a_swap_write, (state == ST_SORT_CMP) && swap, state == ST_SORT_WR, "swap lost")
  `GMSL_IMP(a_gap_done, phase == PH_READING, current_gap == '0, "reading before last pass")

endmodule

// ===== sv/gmsl_ram.sv =====
// Value store with one write port and two registered read ports.
`timescale 1ns / 1ps

module gmsl_ram import gmsl_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr_a,
  input  logic [AW-1:0]         raddr_b,
  output logic [VALUE_BITS-1:0] rdata_a,
  output logic [VALUE_BITS-1:0] rdata_b
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sim/gmsl_merge_checker.sv =====
// Checker that predicts the merged read-out of the gap merge block and compares every result.
`timescale 1ns / 1ps

module gmsl_merge_checker import gmsl_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    item_valid,
  input  logic                    item_ready,
  input  item_t                   item,
  input  logic                    result_valid,
  input  logic                    result_ready,
  input  result_t                 result,
  output int                      mismatches,
  output int                      outstanding
);

  logic signed [VALUE_BITS-1:0] merge_store [MAX_ITEMS];
  int unsigned                  first_len;
  int unsigned                  second_len;
  int unsigned                  fill_count;
  int unsigned                  read_pos;
  bit                           merge_done;
  int                           fail_count;
  result_t                      merged_expect [$];

  function automatic int unsigned next_gap(input int unsigned span);
    return (span <= 1) ? 0 : (span + 1) / 2;
  endfunction

  function automatic void gap_passes();
    int unsigned                  span;
    int unsigned                  k;
    logic signed [VALUE_BITS-1:0] spare;
    for (span = next_gap(fill_count); span > 0; span = next_gap(span)) begin
      for (k = 0; k + span < fill_count; k++) begin
        if (merge_store[k] > merge_store[k + span]) begin
          spare = merge_store[k];
          merge_store[k] = merge_store[k + span];
          merge_store[k + span] = spare;
        end
      end
    end
  endfunction

  function automatic void open_set();
    fill_count = 0;
    read_pos = 0;
    merge_done = 1'b0;
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      first_len = 0;
      second_len = 0;
      fail_count = 0;
      open_set();
      merged_expect.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (merged_expect.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: value %0d from_second %b last %b none_left %b",
                   $time, result.merged_value, result.from_second, result.last,
                   result.none_left);
        end else begin
          want = merged_expect.pop_front();
          if (result !== want) begin
            fail_count++;
            $display("%0t: mismatch: expected value %0d from_second %b last %b none_left %b",
                     $time, want.merged_value, want.from_second, want.last, want.none_left);
            $display("%0t:           got      value %0d from_second %b last %b none_left %b",
                     $time, result.merged_value, result.from_second, result.last,
                     result.none_left);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_COUNT: begin
            first_len = (cfg_data > MAX_ITEMS) ? MAX_ITEMS : cfg_data;
            if (second_len > MAX_ITEMS - first_len) second_len = MAX_ITEMS - first_len;
            open_set();
          end
          REG_SECOND_COUNT: begin
            second_len = (cfg_data > MAX_ITEMS - first_len) ? MAX_ITEMS - first_len : cfg_data;
            open_set();
          end
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        if (item.action == ACT_LOAD) begin
          if (!merge_done && fill_count < first_len + second_len && fill_count < MAX_ITEMS) begin
            merge_store[fill_count] = item.value;
            fill_count++;
          end
        end else begin
          if (!merge_done) begin
            gap_passes();
            merge_done = 1'b1;
          end
          want = '0;
          if (read_pos < fill_count) begin
            want.merged_value = merge_store[read_pos];
            want.from_second = (read_pos >= first_len);
            want.last = (read_pos + 1 == fill_count);
            read_pos++;
          end else begin
            want.none_left = 1'b1;
          end
          merged_expect = {merged_expect, want};
        end
      end
    end
    mismatches <= fail_count;
    outstanding <= merged_expect.size();
  end

endmodule

// ===== sim/tb_gap_merge_two_sorted_lists.sv =====
// Testbench top for the gap merge block: clock, reset, request and result traffic, and verdict.
`timescale 1ns / 1ps

module tb_gap_merge_two_sorted_lists;
  import gmsl_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int MAX_ITEMS    = 1024;
  localparam int ITEM_TARGET  = 1400;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 200000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGES} value_mix_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    item_valid;
  logic                    item_ready;
  item_t                   item;
  logic                    result_valid;
  logic                    result_ready;
  result_t                 result;
  int                      mismatches;
  int                      outstanding;
  int                      quiet_cycles;
  int                      sent_items;
  bit                      sender_steady;
  bit                      hold_request;

  logic signed [VALUE_BITS-1:0] run_vals [MAX_ITEMS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  gap_merge_two_sorted_lists #(.MAX_ITEMS(MAX_ITEMS)) uut (.*);

  gmsl_merge_checker #(.MAX_ITEMS(MAX_ITEMS)) merge_check (.*);

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic act, input logic signed [VALUE_BITS-1:0] v);
    int    idle;
    item_t req;
    idle = sender_steady ? 0 : idle_len();
    if (idle > 0) begin
      item_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req.action = act;
    req.value = v;
    item_valid <= 1'b1;
    item <= req;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_run(input int n, input bit messy);
    int                           k;
    int                           j;
    value_mix_t                   mix;
    logic signed [VALUE_BITS-1:0] v;
    mix = value_mix_t'($urandom_range(0, 2));
    for (k = 0; k < n; k++) begin
      case (mix)
        MIX_WIDE: run_vals[k] = $urandom;
        MIX_NARROW: run_vals[k] = int'($urandom_range(0, 40)) - 20;
        default: begin
          case ($urandom_range(0, 3))
            0: run_vals[k] = VAL_MIN;
            1: run_vals[k] = VAL_MAX;
            2: run_vals[k] = '0;
            default: run_vals[k] = -1;
          endcase
        end
      endcase
    end
    if (!(messy && $urandom_range(0, 2) == 0)) begin
      for (k = 1; k < n; k++) begin
        v = run_vals[k];
        j = k - 1;
        while (j >= 0 && run_vals[j] > v) begin
          run_vals[j + 1] = run_vals[j];
          j--;
        end
        run_vals[j + 1] = v;
      end
    end
    for (k = 0; k < n; k++) begin
      if (messy && $urandom_range(0, 15) == 0) send_item(ACT_READ, $urandom);
      send_item(ACT_LOAD, run_vals[k]);
    end
  endtask

  task automatic run_set(input int first_n, input int second_n, input int reads,
                         input bit messy, input bit squeeze);
    int k;
    int first_cfg;
    int second_cfg;
    drain();
    sender_steady = ($urandom_range(0, 3) == 0);
    first_cfg = messy ? first_n + $urandom_range(0, 2) : first_n;
    second_cfg = messy ? second_n + $urandom_range(0, 2) : second_n;
    if (messy && $urandom_range(0, 1)) begin
      write_reg(REG_SECOND_COUNT, second_cfg);
      write_reg(REG_FIRST_COUNT, first_cfg);
    end else begin
      write_reg(REG_FIRST_COUNT, first_cfg);
      write_reg(REG_SECOND_COUNT, second_cfg);
    end
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    load_run(first_n, messy);
    load_run(second_n, messy);
    if (messy) repeat ($urandom_range(0, 3)) send_item(ACT_LOAD, $urandom);
    if (squeeze) begin
      hold_request = 1'b1;
      sender_steady = 1'b1;
    end
    for (k = 0; k < reads; k++) begin
      if (squeeze && k == reads / 2) drain();
      if (messy && $urandom_range(0, 7) == 0) send_item(ACT_LOAD, $urandom);
      send_item(ACT_READ, $urandom);
    end
  endtask

  initial begin : receiver
    bit steady;
    int pause;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if ($urandom_range(0, 49) == 0) steady = !steady;
        pause = steady ? 0 : idle_len();
        if (pause > 0) begin
          result_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (item_valid && item_ready) ||
        (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int first_n;
    int second_n;
    bit messy;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FIRST_COUNT;
    cfg_data <= '0;
    item_valid <= 1'b0;
    item <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An oversized first count clamps to the store, and reading starts before loading ends.
    write_reg(REG_FIRST_COUNT, 2047);
    write_reg(REG_SECOND_COUNT, 5);
    write_reg(REG_SPARE_LO, 3);
    send_item(ACT_LOAD, VAL_MIN);
    send_item(ACT_LOAD, '0);
    send_item(ACT_LOAD, VAL_MAX);
    repeat (4) send_item(ACT_READ, '0);
    send_item(ACT_LOAD, 7);
    send_item(ACT_READ, -1);
    drain();

    write_reg(REG_FIRST_COUNT, 0);
    write_reg(REG_SECOND_COUNT, 2047);
    write_reg(REG_SPARE_HI, 0);
    send_item(ACT_LOAD, -1);
    send_item(ACT_LOAD, 1);
    repeat (3) send_item(ACT_READ, VAL_MAX);
    drain();

    write_reg(REG_FIRST_COUNT, 2);
    write_reg(REG_SECOND_COUNT, 2);
    send_item(ACT_LOAD, 5);
    send_item(ACT_LOAD, 9);
    send_item(ACT_LOAD, -3);
    send_item(ACT_LOAD, 7);
    send_item(ACT_LOAD, 100);
    repeat (5) send_item(ACT_READ, VAL_MIN);

    run_set(20, 20, 44, 1'b0, 1'b1);
    run_set(600, 424, 24, 1'b0, 1'b0);

    while (sent_items < ITEM_TARGET) begin
      messy = ($urandom_range(0, 4) == 0);
      first_n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 24);
      second_n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 24);
      run_set(first_n, second_n,
              first_n + second_n + (messy ? $urandom_range(1, 3) : $urandom_range(0, 1)),
              messy, 1'b0);
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== gap_merge_two_sorted_lists.f =====
+incdir+sv
sv/gmsl_pkg.sv
sv/gmsl_ram.sv
sv/gap_merge_two_sorted_lists.sv
sim/gmsl_merge_checker.sv
sim/tb_gap_merge_two_sorted_lists.sv
